// ----- rtl/core/mersenne_twister_generator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Mersenne twister generator core: assertion macros
// Shared assertion macros for the generator core. Define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define MTG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define MTG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MTG_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MTG_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/core/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// Mersenne twister generator package
// Types and fixed constants of the MT19937 generator core.
// ----------------------------------------------------------------------------
package mtg_pkg;

   // State array geometry.
   localparam int unsigned StateDepth = 624;
   localparam int unsigned ShiftDist  = 397;
   localparam int unsigned AddrWidth  = $clog2(StateDepth);
   localparam int unsigned WordWidth  = 32;

   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [WordWidth-1:0] word_type;

   // Algorithm constants.
   localparam word_type MatrixA     = 32'h9908_b0df;
   localparam word_type UpperMask   = 32'h8000_0000;
   localparam word_type LowerMask   = 32'h7fff_ffff;
   localparam word_type InitMul     = 32'd1812433253;
   localparam word_type DefaultSeed = 32'd5489;
   localparam word_type TemperB     = 32'h9d2c_5680;
   localparam word_type TemperC     = 32'hefc6_0000;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_RESEED = 2'd0,
      REQ_DRAW32 = 2'd1,
      REQ_DRAW31 = 2'd2
   } req_code_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_DRAW_RD,
      ST_DRAW_WR
   } state_type;

endpackage

// ----- rtl/core/mtg_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mtg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ----- rtl/core/mersenne_twister_generator_core.sv -----
// ----------------------------------------------------------------------------
// Mersenne twister generator core
// MT19937 generator with its 624-word state held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request is transferred when start is high and busy is low. req_type
//   selects reseed (from req_seed), 32-bit draw or 31-bit draw; code 3 is
//   dropped without effect. A draw returns one word on rsp_random_value,
//   marked by rsp_valid for a single cycle; the receiver cannot stall.
//   A reseed returns nothing.
// Draw and reseed sequence:
//   A draw first reads the next word and the word 397 ahead from the RAM,
//   whose read data is registered, then twists, writes back and tempers.
//   rsp_valid follows in the next cycle. busy is low during the write-back,
//   so a new request can be accepted during it. A reseed writes all 624
//   state words, one state word per cycle through the write port. A draw on
//   an unseeded core seeds with 5489 first.
// Reset:
//   Reset returns the core to idle, unseeded, position zero. The RAM is not
//   cleared; it is filled by the first seeding pass.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_core_defines.svh"

module mersenne_twister_generator_core
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   output logic [31:0] rsp_random_value
);

   state_type state_ff, state_in;
   addr_type  pos_ff, pos_in;
   addr_type  idx_ff, idx_in;
   logic      seeded_ff, seeded_in;
   logic      pend_ff, pend_in;
   logic      half_ff, half_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_value_ff, rsp_value_in;
   word_type  prev_ff, prev_in;
   word_type  cur_ff, cur_in;

   logic      accept;
   logic      is_draw;
   logic      idx_last;
   addr_type  nxt_addr;
   addr_type  far_addr;
   logic [AddrWidth:0] far_sum;
   word_type  seed_mix;
   word_type  seed_prod;
   word_type  seed_word;
   word_type  rd_nxt;
   word_type  rd_far;
   word_type  mixed;
   word_type  twisted;
   word_type  t1, t2, t3, t4;
   logic      ram_wr_en;
   addr_type  ram_wr_addr;
   word_type  ram_wr_data;

   // Request decode.
   assign accept   = start && !busy;
   assign is_draw  = req_type inside {REQ_DRAW32, REQ_DRAW31};
   assign idx_last = (idx_ff == addr_type'(StateDepth - 1));

   // Neighbor addresses of the current position, wrapped at the array end.
   assign nxt_addr = (pos_ff == addr_type'(StateDepth - 1)) ? '0 : pos_ff + 1'b1;
   assign far_sum  = {1'b0, pos_ff} + (AddrWidth+1)'(ShiftDist);
   assign far_addr = (far_sum >= (AddrWidth+1)'(StateDepth))
                   ? addr_type'(far_sum - (AddrWidth+1)'(StateDepth))
                   : far_sum[AddrWidth-1:0];

   // Seeding recurrence: x[i] = InitMul * (x[i-1] ^ (x[i-1] >> 30)) + i.
   assign seed_mix  = prev_ff ^ (prev_ff >> 30);
   assign seed_prod = InitMul * seed_mix;
   assign seed_word = (idx_ff == '0) ? prev_ff
                    : seed_prod + WordWidth'(idx_ff);

   // Twist of the word at the current position, then tempering.
   assign mixed   = (cur_ff & UpperMask) | (rd_nxt & LowerMask);
   assign twisted = rd_far ^ (mixed >> 1) ^ (rd_nxt[0] ? MatrixA : '0);
   assign t1      = twisted ^ (twisted >> 11);
   assign t2      = t1 ^ ((t1 << 7) & TemperB);
   assign t3      = t2 ^ ((t2 << 15) & TemperC);
   assign t4      = t3 ^ (t3 >> 18);

   // State memory.
   mtg_ram #(
      .WIDTH(WordWidth),
      .DEPTH(StateDepth)
   ) u_state_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_a_addr (nxt_addr),
      .rd_a_data (rd_nxt),
      .rd_b_addr (far_addr),
      .rd_b_data (rd_far)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SEED: begin
            if (idx_last) begin
               state_in = pend_ff ? ST_DRAW_RD : ST_IDLE;
            end
         end
         ST_DRAW_RD: begin
            state_in = ST_DRAW_WR;
         end
         default: begin
            state_in = ST_IDLE;
            if (accept) begin
               if (req_type == REQ_RESEED) begin
                  state_in = ST_SEED;
               end else if (is_draw) begin
                  state_in = seeded_ff ? ST_DRAW_RD : ST_SEED;
               end
            end
         end
      endcase
   end

   // Sequencer outputs: handshake and memory write port.
   always_comb begin
      busy        = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = twisted;
      case (state_ff)
         ST_SEED: begin
            busy        = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = seed_word;
         end
         ST_DRAW_RD: begin
            busy = 1'b1;
         end
         ST_DRAW_WR: begin
            ram_wr_en = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      seeded_in    = seeded_ff;
      pend_in      = pend_ff;
      half_in      = half_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;

      // Seeding pass, one word per cycle.
      if (state_ff == ST_SEED) begin
         prev_in = seed_word;
         idx_in  = idx_ff + 1'b1;
         pos_in  = '0;
         if (idx_ff == '0) begin
            cur_in = prev_ff;
         end
         if (idx_last) begin
            seeded_in = 1'b1;
         end
      end

      // Twist write-back, advance and result.
      if (state_ff == ST_DRAW_WR) begin
         pos_in       = nxt_addr;
         cur_in       = rd_nxt;
         rsp_valid_in = 1'b1;
         rsp_value_in = half_ff ? (t4 >> 1) : t4;
      end

      // New request transfer.
      if (accept) begin
         if (req_type == REQ_RESEED) begin
            prev_in = req_seed;
            idx_in  = '0;
            pend_in = 1'b0;
         end else if (is_draw) begin
            half_in = (req_type == REQ_DRAW31);
            pend_in = 1'b1;
            if (!seeded_ff) begin
               prev_in = DefaultSeed;
               idx_in  = '0;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         idx_ff       <= '0;
         seeded_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         seeded_ff    <= seeded_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      half_ff      <= half_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // Checks on the sequencer.
   `MTG_ASSERT_IMP(a_pos_range, clock, reset, 1'b1,
      pos_ff < addr_type'(StateDepth), "position left the state array")
   `MTG_ASSERT_IMP(a_draw_seeded, clock, reset, state_ff == ST_DRAW_RD,
      seeded_ff, "draw started on an unseeded state")
   `MTG_ASSERT_NXT(a_draw_result, clock, reset, state_ff == ST_DRAW_WR,
      rsp_valid, "draw write-back gave no result")
   `MTG_ASSERT_IMP(a_result_source, clock, reset, rsp_valid,
      $past(state_ff) == ST_DRAW_WR, "result without a draw write-back")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Mersenne twister generator core testbench
// Drives reseed, 32-bit draw, 31-bit draw and undefined requests into the
// generator through its start/busy command port. It predicts every draw with
// its own MT19937 state copy and compares each strobed result against the
// oldest predicted word. Random sender gaps, a long gap-free stretch and a
// full drain pause exercise the handshake; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb_top
   import mtg_pkg::*;
();

   // Code that the core must drop without effect.
   localparam logic [1:0] ReqUndefined = 2'd3;

   localparam int unsigned RandomItems    = 1750;
   localparam int unsigned WrapRunLength  = 700;
   localparam int unsigned QuietFirst     = 900;
   localparam int unsigned QuietLast      = 1200;
   localparam int unsigned DrainPauseAt   = 1300;
   localparam int unsigned IdlePercent    = 37;
   localparam int unsigned WatchdogLimit  = 5000;
   localparam int unsigned EndDrainCycles = 16;

   // Predicts the generator output and holds the words still to be seen.
   class mt_draw_checker;
      word_type    state_mem[StateDepth];
      int unsigned draw_pos;
      bit          has_seed;
      word_type    expected_words[$];
      int unsigned fail_count;

      function new();
         draw_pos   = 0;
         has_seed   = 1'b0;
         fail_count = 0;
      endfunction

      // Standard initialization recurrence over the whole state array.
      function void seed_state(input word_type seed_value);
         word_type prev;
         state_mem[0] = seed_value;
         for (int unsigned i = 1; i < StateDepth; i++) begin
            prev = state_mem[i-1];
            state_mem[i] = InitMul * (prev ^ (prev >> 30)) + word_type'(i);
         end
         draw_pos = 0;
         has_seed = 1'b1;
      endfunction

      // Twist the word at the current position, write it back, then temper it.
      function word_type twist_and_temper();
         int unsigned cur;
         int unsigned nxt;
         int unsigned far_pos;
         word_type    mixed;
         word_type    y;
         if (!has_seed) begin
            seed_state(DefaultSeed);
         end
         cur     = draw_pos;
         nxt     = (cur + 1) % StateDepth;
         far_pos = (cur + ShiftDist) % StateDepth;
         mixed   = (state_mem[cur] & UpperMask) | (state_mem[nxt] & LowerMask);
         y = state_mem[far_pos] ^ (mixed >> 1) ^ (state_mem[nxt][0] ? MatrixA : '0);
         state_mem[cur] = y;
         draw_pos = nxt;
         y = y ^ (y >> 11);
         y = y ^ ((y << 7) & TemperB);
         y = y ^ ((y << 15) & TemperC);
         y = y ^ (y >> 18);
         return y;
      endfunction

      // Called for every request transfer.
      function void note_request(input logic [1:0] code, input word_type seed_value);
         case (code)
            REQ_RESEED: seed_state(seed_value);
            REQ_DRAW32: expected_words.push_back(twist_and_temper());
            REQ_DRAW31: expected_words.push_back(twist_and_temper() >> 1);
            default: ;
         endcase
      endfunction

      // Called for every result transfer.
      function void check_result(input word_type got);
         word_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               $display("%0t: random_value mismatch, expected %h, actual %h",
                        $time, want, got);
               fail_count++;
            end
         end
      endfunction

      function int unsigned pending_count();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_RESEED;
   logic [31:0] req_seed = '0;
   logic        rsp_valid;
   logic [31:0] rsp_random_value;

   mt_draw_checker tracker = new();
   int unsigned    quiet_cycles = 0;

   mersenne_twister_generator_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_seed         (req_seed),
      .rsp_valid        (rsp_valid),
      .rsp_random_value (rsp_random_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result monitor and watchdog. A cycle without any transfer counts toward
   // the limit.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            tracker.check_result(rsp_random_value);
         end
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Present one request and hold it until the core takes the transfer.
   task automatic send_request(input logic [1:0] code, input word_type seed_value);
      @(negedge clock);
      start    = 1'b1;
      req_type = code;
      req_seed = seed_value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      tracker.note_request(code, seed_value);
   endtask

   // Random sender idle cycles ahead of the next request.
   task automatic sender_gap(input bit quiet);
      if (!quiet) begin
         while ($urandom_range(0, 99) < IdlePercent) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
   endtask

   task automatic wait_drained();
      while (tracker.pending_count() != 0) begin
         @(posedge clock);
      end
   endtask

   // Seeds lean toward the extremes now and then.
   function automatic word_type pick_seed();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return word_type'($urandom_range(0, 255));
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_draw();
      return ($urandom_range(0, 1) == 0) ? REQ_DRAW32 : REQ_DRAW31;
   endfunction

   initial begin
      int unsigned counted;
      int unsigned roll;
      logic [1:0]  code;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The first draw arrives before any reseed and so runs
      // on the default seed.
      send_request(REQ_DRAW32, $urandom);
      send_request(REQ_DRAW31, $urandom);
      send_request(ReqUndefined, $urandom);
      send_request(REQ_DRAW32, '1);
      sender_gap(1'b0);
      send_request(REQ_RESEED, '0);
      send_request(REQ_DRAW32, $urandom);
      send_request(REQ_DRAW31, $urandom);
      send_request(REQ_RESEED, '1);
      sender_gap(1'b0);
      send_request(REQ_DRAW31, $urandom);
      send_request(REQ_DRAW32, $urandom);
      send_request(ReqUndefined, '1);
      send_request(REQ_DRAW32, '0);
      send_request(REQ_RESEED, DefaultSeed);
      send_request(REQ_DRAW32, $urandom);
      send_request(REQ_DRAW32, $urandom);
      send_request(REQ_RESEED, 32'h8000_0000);
      send_request(REQ_DRAW31, $urandom);
      // Back-to-back reseeds: only the second one may count.
      send_request(REQ_RESEED, 32'h0000_0001);
      send_request(REQ_RESEED, 32'haaaa_aaaa);
      send_request(REQ_DRAW32, $urandom);
      send_request(REQ_DRAW31, $urandom);
      send_request(REQ_RESEED, 32'h5555_5555);
      send_request(REQ_DRAW32, $urandom);

      // Random part. The opening run has no reseed so that the position
      // wraps past the end of the state array.
      counted = 0;
      while (counted < RandomItems) begin
         if (counted == DrainPauseAt) begin
            @(negedge clock);
            start = 1'b0;
            wait_drained();
         end
         sender_gap(counted >= QuietFirst && counted < QuietLast);
         roll = $urandom_range(0, 999);
         if (roll < 20) begin
            code = ReqUndefined;
         end else if (roll < 45 && counted >= WrapRunLength) begin
            code = REQ_RESEED;
         end else begin
            code = pick_draw();
         end
         send_request(code, pick_seed());
         if (code != ReqUndefined) begin
            counted++;
         end
      end

      // Drain, then wait EndDrainCycles more clocks for any stray result.
      @(negedge clock);
      start = 1'b0;
      wait_drained();
      repeat (EndDrainCycles) @(posedge clock);

      if (tracker.fail_count == 0 && tracker.pending_count() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mtg_pkg.sv
rtl/core/mtg_ram.sv
rtl/core/mersenne_twister_generator_core.sv
tb/tb_top.sv
